// ----- rtl/brsc_pkg.sv -----
// Package for the bounded run sequence counter.
// Field widths, the modulus and the accumulator control word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brsc_pkg;

	localparam int MAX_COUNT_DEF = 128;
	localparam int IN_W = 8;
	localparam int OUT_W = 27;
	localparam logic [OUT_W-1:0] MODULUS = OUT_W'(100000000);

	typedef struct packed {
		logic init;
		logic seed;
		logic add;
	} acc_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/bounded_run_sequence_counter.sv -----
// Top level: sequencer, count table memory, row memory and result register.
// Depends on brsc_pkg and brsc_accum.
//
// channel  direction  ports                                           handshake
// query    in         count_a, count_b, run_limit_a, run_limit_b      start & !busy
// result   out        arrangement_count                               done (1 cycle)
//
// Per query: every cell (a,b) up to (count_a,count_b) gets an A pass and a B pass;
// a pass reads as many table entries as its run bound (min(ka,a) or min(kb,b)). After
// all passes busy stays high through S_FIN1, S_FIN2 and S_OUT; done comes in the cycle after.
// Oversized counts or an empty query answer straight from idle without raising busy.
// Reset clears control only; the memories are written before being read.
// The receiver cannot stall: done pulses for one cycle with the word.
`timescale 1ns / 1ps
`default_nettype none

module bounded_run_sequence_counter #(
	parameter int MAX_COUNT = brsc_pkg::MAX_COUNT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire [brsc_pkg::IN_W-1:0]     count_a,
	input  wire [brsc_pkg::IN_W-1:0]     count_b,
	input  wire [brsc_pkg::IN_W-1:0]     run_limit_a,
	input  wire [brsc_pkg::IN_W-1:0]     run_limit_b,
	output logic                         done,
	output logic [brsc_pkg::OUT_W-1:0]   arrangement_count
);
	import brsc_pkg::*;

	localparam int STRIDE = MAX_COUNT + 1;
	localparam int DEPTH = STRIDE * STRIDE;
	localparam int CW = $clog2(STRIDE);
	localparam int AW = $clog2(DEPTH);
	localparam int CMPW = (CW > IN_W) ? CW : IN_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CELL = 3'd1;
	localparam logic [2:0] S_RUN  = 3'd2;
	localparam logic [2:0] S_FIN1 = 3'd3;
	localparam logic [2:0] S_FIN2 = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam logic PH_A = 1'b0;
	localparam logic PH_B = 1'b1;

	logic [2:0]       state_q;
	logic             phase_q;
	logic [CW-1:0]    a_q, b_q, na_q, nb_q, cnt_q;
	logic [IN_W-1:0]  ka_q, kb_q;
	logic [AW-1:0]    rowbase_q, ptr_q;
	logic             rd_v_s1;
	logic             done_q;
	logic [OUT_W-1:0] result_q;

	logic [OUT_W-1:0] b_mem [DEPTH];
	logic [OUT_W-1:0] a_mem [STRIDE];
	logic [OUT_W-1:0] b_rdata_q, a_rdata_q;

	logic             accept, too_big, is_empty;
	logic             cell_end, b_re, a_re, b_we, a_we;
	logic [CW-1:0]    a_raddr, lim;
	logic [AW-1:0]    b_waddr;
	acc_ctl_t         acc_ctl;
	logic [OUT_W-1:0] acc_data, acc;

	assign accept   = start && !busy;
	assign too_big  = (CMPW'(count_a) > CMPW'(MAX_COUNT)) || (CMPW'(count_b) > CMPW'(MAX_COUNT));
	assign is_empty = (count_a == '0) && (count_b == '0);

	assign cell_end = (state_q == S_RUN) && (cnt_q == '0) && !rd_v_s1;
	assign b_re = (state_q == S_RUN) && (cnt_q != '0) && (phase_q == PH_A);
	assign a_re = ((state_q == S_RUN) && (cnt_q != '0) && (phase_q == PH_B))
		|| (state_q == S_FIN1);
	assign a_we = cell_end && (phase_q == PH_A);
	assign b_we = cell_end && (phase_q == PH_B);
	assign a_raddr = (state_q == S_FIN1) ? nb_q : ptr_q[CW-1:0];
	assign b_waddr = rowbase_q + AW'(b_q);

	always_comb begin
		if (phase_q == PH_A) begin
			lim = (CMPW'(ka_q) < CMPW'(a_q)) ? CW'(ka_q) : a_q;
		end else begin
			lim = (CMPW'(kb_q) < CMPW'(b_q)) ? CW'(kb_q) : b_q;
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[b_waddr] <= acc;
		end
		if (b_re) begin
			b_rdata_q <= b_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[b_q] <= acc;
		end
		if (a_re) begin
			a_rdata_q <= a_mem[a_raddr];
		end
	end

	always_comb begin
		acc_ctl.init = (state_q == S_CELL);
		acc_ctl.seed = (a_q == '0) && (b_q == '0);
		acc_ctl.add  = ((state_q == S_RUN) && rd_v_s1) || (state_q == S_FIN2);
		acc_data = ((phase_q == PH_A) && (state_q == S_RUN)) ? b_rdata_q : a_rdata_q;
	end

	brsc_accum u_accum (
		.clk  (clk),
		.ctl  (acc_ctl),
		.data (acc_data),
		.acc  (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_A;
			rd_v_s1   <= 1'b0;
			done_q    <= 1'b0;
			a_q       <= '0;
			b_q       <= '0;
			cnt_q     <= '0;
			rowbase_q <= '0;
		end else begin
			done_q  <= (accept && (too_big || is_empty)) || (state_q == S_OUT);
			rd_v_s1 <= b_re || ((state_q == S_RUN) && (cnt_q != '0) && (phase_q == PH_B));
			case (state_q)
				S_IDLE: begin
					if (accept && !too_big && !is_empty) begin
						state_q   <= S_CELL;
						phase_q   <= PH_A;
						a_q       <= '0;
						b_q       <= '0;
						rowbase_q <= '0;
					end
				end
				S_CELL: begin
					cnt_q   <= lim;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end else if (!rd_v_s1) begin
						if (b_q == nb_q) begin
							b_q <= '0;
							if (phase_q == PH_A) begin
								phase_q <= PH_B;
								state_q <= S_CELL;
							end else if (a_q == na_q) begin
								state_q <= S_FIN1;
							end else begin
								state_q   <= S_CELL;
								phase_q   <= PH_A;
								a_q       <= a_q + CW'(1);
								rowbase_q <= rowbase_q + AW'(STRIDE);
							end
						end else begin
							state_q <= S_CELL;
							b_q     <= b_q + CW'(1);
						end
					end
				end
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query latches, table pointer and result word (no reset needed)
	always_ff @(posedge clk) begin
		if (accept) begin
			na_q     <= CW'(count_a);
			nb_q     <= CW'(count_b);
			ka_q     <= run_limit_a;
			kb_q     <= run_limit_b;
			result_q <= (!too_big && is_empty) ? OUT_W'(1) : '0;
		end
		if (state_q == S_CELL) begin
			if (phase_q == PH_A) begin
				ptr_q <= rowbase_q - AW'(STRIDE) + AW'(b_q);
			end else begin
				ptr_q <= AW'(b_q) - AW'(1);
			end
		end else if (b_re) begin
			ptr_q <= ptr_q - AW'(STRIDE);
		end else if (a_re && (state_q == S_RUN)) begin
			ptr_q <= ptr_q - AW'(1);
		end
		if (state_q == S_OUT) begin
			result_q <= acc;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign arrangement_count = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_IDLE))
		else $error("done outside idle");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (arrangement_count < MODULUS))
		else $error("result not reduced");

	a_read_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> ($past(state_q) == S_RUN))
		else $error("read data without issue");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted query dropped");

	a_no_write_while_reading: assert property (@(posedge clk) disable iff (!arst_n)
		(a_we || b_we) |-> (!rd_v_s1 && (cnt_q == '0)))
		else $error("write before sum complete");

endmodule

`default_nettype wire

// ----- rtl/brsc_accum.sv -----
// Shared modular accumulator: acc <= (acc + data) mod 1e8, or load 0 / 1.
// Depends on brsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brsc_accum (
	input  wire                          clk,
	input  brsc_pkg::acc_ctl_t           ctl,
	input  wire [brsc_pkg::OUT_W-1:0]    data,
	output logic [brsc_pkg::OUT_W-1:0]   acc
);
	import brsc_pkg::*;

	logic [OUT_W-1:0] acc_q;
	logic [OUT_W:0]   sum;
	logic [OUT_W:0]   red;

	assign sum = {1'b0, acc_q} + {1'b0, data};
	assign red = (sum >= {1'b0, MODULUS}) ? (sum - {1'b0, MODULUS}) : sum;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			acc_q <= ctl.seed ? OUT_W'(1) : '0;
		end else if (ctl.add) begin
			acc_q <= red[OUT_W-1:0];
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire
